FILE: hw/rtl/lphi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash insert package
// Shared widths, constants, types and the table access request structure.
// ----------------------------------------------------------------------------
package lphi_pkg;

  // Table geometry.
  localparam int MAX_SLOTS  = 1024;
  localparam int ADDR_BITS  = $clog2(MAX_SLOTS);
  localparam int LIMIT_BITS = ADDR_BITS + 1;
  localparam int TAG_BITS   = 16;
  localparam int WORD_BITS  = TAG_BITS + 1;

  // Arithmetic widths of the home slot computation.
  localparam int CODE_BITS  = 15;
  localparam int DVSR_BITS  = 10;
  localparam int QUO_BITS   = CODE_BITS;
  localparam int HOME_BITS  = QUO_BITS + 3;
  localparam int CNT_BITS   = $clog2(QUO_BITS);

  localparam int BASE_OFFSET = 351;
  localparam int SLOT_STRIDE = 5;

  // Configuration registers.
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 11;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIVISOR      = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SLOTS_IN_USE = 2'd1;
  localparam int DIVISOR_RESET      = 460;
  localparam int SLOTS_IN_USE_RESET = 200;

  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [LIMIT_BITS-1:0] lim_t;
  typedef logic [TAG_BITS-1:0]   tag_t;
  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [CODE_BITS-1:0]  code_t;
  typedef logic [DVSR_BITS-1:0]  dvsr_t;
  typedef logic [QUO_BITS-1:0]   quo_t;
  typedef logic [HOME_BITS-1:0]  home_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  // One table access per cycle: a write port and a read port.
  typedef struct packed {
    logic  wr_en;
    addr_t wr_addr;
    word_t wr_data;
    addr_t rd_addr;
  } mem_req_t;

endpackage

FILE: hw/rtl/lphi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash insert divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lphi_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  lphi_pkg::code_t dividend,
  input  lphi_pkg::dvsr_t divisor,
  output logic            done,
  output lphi_pkg::quo_t  quotient
);

  logic                  busy;
  lphi_pkg::cnt_t        cnt;
  lphi_pkg::dvsr_t       rem;
  lphi_pkg::dvsr_t       dvsr;
  lphi_pkg::quo_t        work;
  logic [lphi_pkg::DVSR_BITS:0] trial;
  logic                  fits;
  lphi_pkg::dvsr_t       rem_next;

  // Shift in the next dividend bit and try a subtraction.
  always_comb begin
    trial    = {rem, work[lphi_pkg::QUO_BITS-1]};
    fits     = trial >= {1'b0, dvsr};
    rem_next = fits ? lphi_pkg::dvsr_t'(trial - {1'b0, dvsr})
                    : trial[lphi_pkg::DVSR_BITS-1:0];
  end

  assign done     = busy && (cnt == lphi_pkg::cnt_t'(lphi_pkg::QUO_BITS - 1));
  assign quotient = work;

  // The work register holds the remaining dividend bits and collects quotient bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= '0;
      dvsr <= divisor;
      work <= dividend;
    end else if (busy) begin
      rem  <= rem_next;
      work <= {work[lphi_pkg::QUO_BITS-2:0], fits};
      cnt  <= cnt + lphi_pkg::cnt_t'(1);
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/lphi_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash insert table
// Slot memory holding an occupied flag over the stored tag, registered reads.
// ----------------------------------------------------------------------------
module lphi_table (
  input  logic               clk,
  input  lphi_pkg::mem_req_t req,
  output lphi_pkg::word_t    rd_data
);

  lphi_pkg::word_t mem [lphi_pkg::MAX_SLOTS];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

FILE: hw/rtl/linear_probe_hash_insert_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash insert unit
// Computes a home slot from a name code, walks the slot table upward to the
// first free slot below the limit and stores the entry tag there, else reports full.
// ----------------------------------------------------------------------------
// Flow: a request runs through the bit-serial divider, the home slot check and
// the probe walk, which reads one slot per cycle; when the home slot lies past
// the limit no slot is examined. A new request is accepted only once the
// result is in the output register and the controller is idle again.
// Reset: a clearing pass empties the table, no request is accepted meanwhile;
// configuration writes are taken at all times.
// ----------------------------------------------------------------------------
module linear_probe_hash_insert_unit (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [lphi_pkg::CODE_BITS-1:0]          name_code,
  input  logic [lphi_pkg::TAG_BITS-1:0]           entry_tag,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [lphi_pkg::ADDR_BITS-1:0]          slot,
  output logic                                    collided,
  output logic                                    full_res,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [lphi_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [lphi_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_HOME,
    S_PROBE,
    S_DONE
  } state_t;

  state_t             state;
  lphi_pkg::addr_t    clr_addr;
  lphi_pkg::dvsr_t    divisor;
  lphi_pkg::lim_t     slots_in_use;
  lphi_pkg::tag_t     tag;
  lphi_pkg::addr_t    home;
  lphi_pkg::lim_t     issue_addr;
  lphi_pkg::lim_t     chk_addr;
  logic               rd_pend;
  logic               first;
  lphi_pkg::addr_t    res_slot;
  logic               res_hit;
  logic               res_full;

  lphi_pkg::lim_t     limit;
  lphi_pkg::code_t    dividend;
  lphi_pkg::dvsr_t    divisor_eff;
  lphi_pkg::home_t    home_big;
  logic               in_range;
  logic               issue;
  logic               accept;
  logic               occ;
  logic               found;
  logic               div_done;
  lphi_pkg::quo_t     div_q;
  lphi_pkg::mem_req_t mem_req;
  lphi_pkg::word_t    rd_data;

  // Handshakes.
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Usable limit, offset name code and the divisor with zero read as one.
  always_comb begin
    limit = (slots_in_use > lphi_pkg::lim_t'(lphi_pkg::MAX_SLOTS))
          ? lphi_pkg::lim_t'(lphi_pkg::MAX_SLOTS) : slots_in_use;
    dividend = (name_code >= lphi_pkg::code_t'(lphi_pkg::BASE_OFFSET))
             ? lphi_pkg::code_t'(name_code - lphi_pkg::code_t'(lphi_pkg::BASE_OFFSET))
             : '0;
    divisor_eff = (divisor == '0) ? lphi_pkg::dvsr_t'(1) : divisor;
  end

  // Home slot and its range check.
  always_comb begin
    home_big = lphi_pkg::home_t'(div_q) * lphi_pkg::home_t'(lphi_pkg::SLOT_STRIDE);
    in_range = home_big < lphi_pkg::home_t'(limit);
  end

  // Probe walk: one read issued and one slot checked per cycle.
  always_comb begin
    issue = (state == S_PROBE) && (issue_addr < limit);
    occ   = rd_data[lphi_pkg::TAG_BITS];
    found = (state == S_PROBE) && rd_pend && !occ;
  end

  // Table requests: clearing pass, or the tag write into the free slot.
  always_comb begin
    mem_req.rd_addr = issue_addr[lphi_pkg::ADDR_BITS-1:0];
    if (state == S_CLEAR) begin
      mem_req.wr_en   = 1'b1;
      mem_req.wr_addr = clr_addr;
      mem_req.wr_data = '0;
    end else begin
      mem_req.wr_en   = found;
      mem_req.wr_addr = chk_addr[lphi_pkg::ADDR_BITS-1:0];
      mem_req.wr_data = {1'b1, tag};
    end
  end

  lphi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (dividend),
    .divisor  (divisor_eff),
    .done     (div_done),
    .quotient (div_q)
  );

  lphi_table u_table (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      divisor      <= lphi_pkg::dvsr_t'(lphi_pkg::DIVISOR_RESET);
      slots_in_use <= lphi_pkg::lim_t'(lphi_pkg::SLOTS_IN_USE_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lphi_pkg::REG_DIVISOR: begin
          divisor <= cfg_data[lphi_pkg::DVSR_BITS-1:0];
        end
        lphi_pkg::REG_SLOTS_IN_USE: begin
          slots_in_use <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Controller and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      // A taken result empties the output register, unless a new one loads it.
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + lphi_pkg::addr_t'(1);
          if (clr_addr == lphi_pkg::addr_t'(lphi_pkg::MAX_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            tag   <= entry_tag;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_HOME;
          end
        end
        S_HOME: begin
          home       <= home_big[lphi_pkg::ADDR_BITS-1:0];
          issue_addr <= lphi_pkg::lim_t'(home_big[lphi_pkg::ADDR_BITS-1:0]);
          rd_pend    <= 1'b0;
          first      <= 1'b1;
          if (in_range) begin
            state <= S_PROBE;
          end else begin
            res_slot <= home_big[lphi_pkg::ADDR_BITS-1:0];
            res_hit  <= 1'b0;
            res_full <= 1'b1;
            state    <= S_DONE;
          end
        end
        S_PROBE: begin
          rd_pend  <= issue;
          chk_addr <= issue_addr;
          if (issue) begin
            issue_addr <= issue_addr + lphi_pkg::lim_t'(1);
          end
          if (rd_pend) begin
            first <= 1'b0;
            if (first) begin
              res_hit <= occ;
            end
            if (!occ) begin
              res_slot <= chk_addr[lphi_pkg::ADDR_BITS-1:0];
              res_full <= 1'b0;
              state    <= S_DONE;
            end else if (lphi_pkg::lim_t'(chk_addr + lphi_pkg::lim_t'(1)) == limit) begin
              res_slot <= home;
              res_full <= 1'b1;
              state    <= S_DONE;
            end
          end
        end
        S_DONE: begin
          rd_pend <= 1'b0;
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            slot      <= res_slot;
            collided  <= res_hit;
            full_res  <= res_full;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // An accepted request always starts the divider.
  a_accept_div: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_DIV))
    else $error("accepted request did not enter division");

  // The divider finishes only while the controller waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside division");

  // A tag write never lands at or beyond the usable limit.
  a_write_limit: assert property (@(posedge clk) disable iff (rst)
    (mem_req.wr_en && (state == S_PROBE)) |->
      (lphi_pkg::lim_t'(mem_req.wr_addr) < limit))
    else $error("tag write beyond the slot limit");

  // No request is taken during the clearing pass.
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall)
    else $error("request accepted while clearing");
`endif

endmodule

FILE: tb/lphi_insert_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash insert checker
// Watches the request, result and configuration channels of the insert unit.
// It keeps its own copy of the registers and the occupancy map, predicts the
// slot, collision and full flags of every accepted request, and compares
// each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module lphi_insert_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [lphi_pkg::CODE_BITS-1:0]    name_code,
  input  logic [lphi_pkg::TAG_BITS-1:0]     entry_tag,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [lphi_pkg::ADDR_BITS-1:0]    slot,
  input  logic                              collided,
  input  logic                              full_res,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [lphi_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [lphi_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output int                                inserts_outstanding,
  output int                                mismatch_count
);

  typedef struct packed {
    lphi_pkg::addr_t slot;
    logic            collided;
    logic            full_res;
  } insert_result_t;

  // Shadow copy of the registers and the occupancy map.
  lphi_pkg::dvsr_t divisor_q;
  lphi_pkg::lim_t  slots_in_use_q;
  logic            occupied [lphi_pkg::MAX_SLOTS];

  insert_result_t predicted_q [$];

  // Works out where an insert lands and marks that slot as taken.
  function automatic insert_result_t place_entry(lphi_pkg::code_t code);
    lphi_pkg::dvsr_t dv;
    lphi_pkg::lim_t  limit;
    lphi_pkg::home_t home;
    lphi_pkg::home_t pos;
    insert_result_t  res;
    dv    = (divisor_q == '0) ? lphi_pkg::dvsr_t'(1) : divisor_q;
    limit = (slots_in_use_q > lphi_pkg::MAX_SLOTS)
          ? lphi_pkg::lim_t'(lphi_pkg::MAX_SLOTS) : slots_in_use_q;
    // Codes below the offset would give a negative quotient; they go home to 0.
    if (code < lphi_pkg::BASE_OFFSET) begin
      home = '0;
    end else begin
      home = lphi_pkg::home_t'(((code - lphi_pkg::BASE_OFFSET) / dv)
                               * lphi_pkg::SLOT_STRIDE);
    end
    res.collided = (home < limit) && occupied[home[lphi_pkg::ADDR_BITS-1:0]];
    res.full_res = 1'b1;
    res.slot     = home[lphi_pkg::ADDR_BITS-1:0];
    // Walk upward without wrapping; the first free slot below the limit wins.
    for (pos = home; pos < limit; pos++) begin
      if (!occupied[pos[lphi_pkg::ADDR_BITS-1:0]]) begin
        occupied[pos[lphi_pkg::ADDR_BITS-1:0]] = 1'b1;
        res.full_res = 1'b0;
        res.slot     = pos[lphi_pkg::ADDR_BITS-1:0];
        break;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    insert_result_t exp_res;
    if (rst) begin
      divisor_q      = lphi_pkg::dvsr_t'(lphi_pkg::DIVISOR_RESET);
      slots_in_use_q = lphi_pkg::lim_t'(lphi_pkg::SLOTS_IN_USE_RESET);
      foreach (occupied[i]) occupied[i] = 1'b0;
      predicted_q.delete();
      mismatch_count = 0;
    end else begin
      // Register writes; unknown indexes are ignored.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lphi_pkg::REG_DIVISOR: begin
            divisor_q = cfg_data[lphi_pkg::DVSR_BITS-1:0];
          end
          lphi_pkg::REG_SLOTS_IN_USE: begin
            slots_in_use_q = cfg_data;
          end
          default: begin
          end
        endcase
      end

      if (in_valid && !in_stall) begin
        predicted_q.push_back(place_entry(name_code));
      end

      // Compare each accepted result with the oldest prediction.
      if (out_valid && !out_stall) begin
        if (predicted_q.size() == 0) begin
          $error("unexpected result: slot %0d collided %0b full_res %0b",
                 slot, collided, full_res);
          mismatch_count++;
        end else begin
          exp_res = predicted_q.pop_front();
          if (slot !== exp_res.slot) begin
            $error("slot: expected %0d, actual %0d", exp_res.slot, slot);
            mismatch_count++;
          end
          if (collided !== exp_res.collided) begin
            $error("collided: expected %0b, actual %0b", exp_res.collided, collided);
            mismatch_count++;
          end
          if (full_res !== exp_res.full_res) begin
            $error("full_res: expected %0b, actual %0b", exp_res.full_res, full_res);
            mismatch_count++;
          end
        end
      end
    end
    inserts_outstanding <= predicted_q.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear probe hash insert testbench
// Drives directed and random insert requests through several register
// settings with random gaps and result stalls; a checker beside the unit
// predicts and compares every result and this top reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  // Index with no register behind it; writes to it must change nothing.
  localparam logic [lphi_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  localparam int PHASES     = 9;
  localparam int PHASE_REQS = 48;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  lphi_pkg::code_t name_code = '0;
  lphi_pkg::tag_t  entry_tag = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  lphi_pkg::addr_t slot;
  logic            collided;
  logic            full_res;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [lphi_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [lphi_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  int inserts_outstanding;
  int mismatch_count;
  int send_pct = 35;
  int recv_pct = 49;

  linear_probe_hash_insert_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .name_code (name_code),
    .entry_tag (entry_tag),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .slot      (slot),
    .collided  (collided),
    .full_res  (full_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lphi_insert_checker checker_i (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .name_code           (name_code),
    .entry_tag           (entry_tag),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .slot                (slot),
    .collided            (collided),
    .full_res            (full_res),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .inserts_outstanding (inserts_outstanding),
    .mismatch_count      (mismatch_count)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Random result stalls at the current rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_pct);
  end

  // Waits until every predicted result has come out, then lets the pipe settle.
  task automatic wait_drained();
    @(posedge clk);
    while (inserts_outstanding != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  // Writes both registers in one burst; valid stays high between the writes.
  task automatic configure(lphi_pkg::dvsr_t dv, lphi_pkg::lim_t limit);
    cfg_valid <= 1'b1;
    cfg_index <= lphi_pkg::REG_DIVISOR;
    cfg_data  <= {1'b0, dv};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= lphi_pkg::REG_SLOTS_IN_USE;
    cfg_data  <= limit;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Issues one insert request, optionally after a random gap or a full drain.
  task automatic send_insert(lphi_pkg::code_t code, lphi_pkg::tag_t tag, bit drain_first);
    if (drain_first) begin
      in_valid <= 1'b0;
      wait_drained();
    end else if ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    in_valid  <= 1'b1;
    name_code <= code;
    entry_tag <= tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stimulus.
  initial begin
    int              lim_val;
    int              dv_val;
    lphi_pkg::code_t code;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings: small codes, repeated homes,
    // the largest codes and a home beyond the limit.
    send_insert(15'd0, 16'h0000, 1'b0);
    send_insert(15'd350, 16'hFFFF, 1'b0);
    send_insert(15'd351, 16'h1234, 1'b0);
    send_insert(15'd17575, 16'hA5A5, 1'b0);
    send_insert(15'd17575, 16'h5A5A, 1'b0);
    send_insert(15'h7FFF, 16'hFFFF, 1'b0);
    send_insert(15'h4000, 16'h0001, 1'b0);
    in_valid <= 1'b0;
    wait_drained();

    // Zero divisor and a limit above the table: fill the top slots, run the
    // walk into the limit, then land homes past the end.
    configure(lphi_pkg::dvsr_t'(0), lphi_pkg::lim_t'(11'h7FF));
    send_insert(15'd555, 16'h0F0F, 1'b0);
    send_insert(15'd555, 16'hF0F0, 1'b0);
    send_insert(15'd555, 16'h3C3C, 1'b0);
    send_insert(15'd555, 16'hC3C3, 1'b0);
    send_insert(15'd555, 16'h8001, 1'b0);
    send_insert(15'd556, 16'h7FFE, 1'b0);
    send_insert(15'h7FFF, 16'h0000, 1'b0);
    in_valid <= 1'b0;
    wait_drained();

    // Largest divisor with a zero limit: every insert is full.
    configure(lphi_pkg::dvsr_t'(1023), lphi_pkg::lim_t'(0));
    send_insert(15'd17575, 16'hBEEF, 1'b0);
    send_insert(15'd100, 16'h4242, 1'b0);
    in_valid <= 1'b0;
    wait_drained();

    // A write to an unused index, then a one-slot table that is already taken.
    cfg_valid <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_data  <= '0;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    configure(lphi_pkg::dvsr_t'(1023), lphi_pkg::lim_t'(1));
    send_insert(15'd0, 16'h1111, 1'b0);
    send_insert(15'h7FFF, 16'h2222, 1'b0);
    in_valid <= 1'b0;

    // Random phases: each picks a limit and a divisor that spreads the homes
    // over it, with an occasional fully random divisor or oversized limit.
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p == 3) begin
        send_pct = 49;
        recv_pct <= 35;
      end else if (p == 6) begin
        send_pct = 0;
        recv_pct <= 0;
      end
      lim_val = $urandom_range(32, 1024);
      dv_val  = 86120 / lim_val;
      dv_val  = dv_val + $urandom_range(0, dv_val);
      if (dv_val > 1023) dv_val = 1023;
      if ($urandom_range(4) == 0) dv_val = $urandom_range(0, 1023);
      if ($urandom_range(3) == 0) lim_val = 2047;
      configure(lphi_pkg::dvsr_t'(dv_val), lphi_pkg::lim_t'(lim_val));
      for (int i = 0; i < PHASE_REQS; i++) begin
        case ($urandom_range(9))
          0: code = lphi_pkg::code_t'($urandom_range(0, 350));
          1: code = lphi_pkg::code_t'($urandom_range(0, 32767));
          default: code = lphi_pkg::code_t'($urandom_range(0, 17575));
        endcase
        send_insert(code, lphi_pkg::tag_t'($urandom), (p == 4) && (i == PHASE_REQS / 2));
      end
      in_valid <= 1'b0;
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
